@@ design/hs_pkg.sv @@
// Shared constants and types for the heap sorter.
`timescale 1ns / 1ps
package hs_pkg;

	localparam int ITEM_W        = 32;
	localparam int DEF_MAX_ITEMS = 64;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_TOP,
		ST_TOPW,
		ST_KID,
		ST_KID2,
		ST_CMP,
		ST_PUT,
		ST_X0,
		ST_XR,
		ST_XK,
		ST_ERD,
		ST_EOUT
	} hs_state_t;

endpackage

@@ design/hs_stream_if.sv @@
// Valid/ready channel interfaces for the heap sorter input and result streams.
`timescale 1ns / 1ps
interface hs_in_if import hs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ITEM_W-1:0] element_value;
	logic                     is_last;

	modport source (output valid, element_value, is_last, input ready);
	modport sink   (input valid, element_value, is_last, output ready);
endinterface

interface hs_out_if import hs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ITEM_W-1:0] sorted_value;
	logic                     run_end;
	logic                     overflowed;

	modport source (output valid, sorted_value, run_end, overflowed, input ready);
	modport sink   (input valid, sorted_value, run_end, overflowed, output ready);
endinterface

@@ design/hs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module hs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// Read data holds while no read is issued.
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/heap_sorter_unit.sv @@
// Heap sorter: loads a set of signed values, heapsorts them in RAM, emits them ascending.
// Loading accepts one beat per cycle; the beat marked last closes the set.
// Sorting runs about 1.5*N sift passes on the one RAM.
// Emitting reads each result from RAM, then loads it into the output register, waiting while the output is stalled.
// No new set is accepted between the last beat of a set and its final result loading.
// Reset (arst_n low) returns to loading with an empty set; RAM contents are not cleared.
`timescale 1ns / 1ps
module heap_sorter_unit import hs_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input  logic      clk,
	input  logic      arst_n,
	hs_in_if.sink     items,
	hs_out_if.source  results
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = AW + 1;
	localparam int KW = AW + 1;

	hs_state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          build_q;
	logic          out_valid_q;

	logic [AW-1:0] top_q, last_q, hole_q, k_q, emit_idx_q;
	logic [KW-1:0] kid_q;
	logic signed [ITEM_W-1:0] carried_q, kval_q;
	logic signed [ITEM_W-1:0] out_value_q;
	logic          out_end_q, out_ovf_q;

	// RAM port
	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	logic [ITEM_W-1:0] wdata, rdata_raw;
	logic signed [ITEM_W-1:0] rdata;

	// Derived values
	logic          accept, has_room, store_it, out_load, emit_final;
	logic [CW-1:0] n_new, n_new_m1;
	logic [KW-1:0] last_ext, kid_first, kid_next;

	hs_ram #(
		.WIDTH (ITEM_W),
		.DEPTH (MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	assign rdata      = $signed(rdata_raw);
	assign has_room   = (count_q < CW'(MAX_ITEMS));
	assign accept     = (state_q == ST_LOAD) && items.valid;
	assign store_it   = accept && has_room;
	assign n_new      = count_q + CW'(has_room);
	assign n_new_m1   = n_new - CW'(1);
	assign last_ext   = {1'b0, last_q};
	assign kid_first  = {top_q, 1'b1};
	assign kid_next   = {kid_q[AW-1:0], 1'b1};
	assign emit_final = ({1'b0, emit_idx_q} + KW'(1)) == KW'(count_q);
	assign out_load   = (state_q == ST_EOUT) && (!out_valid_q || results.ready);

	assign items.ready        = (state_q == ST_LOAD);
	assign results.valid      = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.run_end    = out_end_q;
	assign results.overflowed = out_ovf_q;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = hole_q;
		wdata   = carried_q;
		re      = 1'b0;
		raddr   = top_q;
		case (state_q)
			ST_LOAD: begin
				if (store_it) begin
					we    = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = items.element_value;
				end
				if (accept && items.is_last) begin
					state_d = (n_new < CW'(2)) ? ST_ERD : ST_TOP;
				end
			end
			ST_TOP: begin
				re      = 1'b1;
				raddr   = top_q;
				state_d = ST_TOPW;
			end
			ST_TOPW: begin
				if (kid_first > last_ext) begin
					state_d = ST_PUT;
				end else begin
					re      = 1'b1;
					raddr   = kid_first[AW-1:0];
					state_d = ST_KID;
				end
			end
			ST_KID: begin
				if (kid_q < last_ext) begin
					re      = 1'b1;
					raddr   = kid_q[AW-1:0] + AW'(1);
					state_d = ST_KID2;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_KID2: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (kval_q > carried_q) begin
					we    = 1'b1;
					waddr = hole_q;
					wdata = kval_q;
					if (kid_next > last_ext) begin
						state_d = ST_PUT;
					end else begin
						re      = 1'b1;
						raddr   = kid_next[AW-1:0];
						state_d = ST_KID;
					end
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = hole_q;
				wdata = carried_q;
				if (build_q) begin
					state_d = (top_q == '0) ? ST_X0 : ST_TOP;
				end else begin
					state_d = (k_q == AW'(1)) ? ST_ERD : ST_X0;
				end
			end
			ST_X0: begin
				re      = 1'b1;
				raddr   = '0;
				state_d = ST_XR;
			end
			ST_XR: begin
				re      = 1'b1;
				raddr   = k_q;
				state_d = ST_XK;
			end
			ST_XK: begin
				// The old root moves to the end of the heap; the last slot's value sifts from the root.
				we    = 1'b1;
				waddr = k_q;
				wdata = kval_q;
				if (k_q == AW'(1)) begin
					state_d = ST_PUT;
				end else begin
					re      = 1'b1;
					raddr   = AW'(1);
					state_d = ST_KID;
				end
			end
			ST_ERD: begin
				re      = 1'b1;
				raddr   = emit_idx_q;
				state_d = ST_EOUT;
			end
			ST_EOUT: begin
				if (out_load) begin
					state_d = emit_final ? ST_LOAD : ST_ERD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			build_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= n_new;
				if (!has_room) begin
					ovf_q <= 1'b1;
				end
			end
			if (accept && items.is_last) begin
				build_q <= 1'b1;
			end else if (state_q == ST_PUT && build_q && top_q == '0) begin
				build_q <= 1'b0;
			end
			if (out_load && emit_final) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				top_q      <= n_new_m1[AW:1];
				last_q     <= n_new_m1[AW-1:0];
				emit_idx_q <= '0;
			end
			ST_TOPW: begin
				carried_q <= rdata;
				hole_q    <= top_q;
				kid_q     <= kid_first;
			end
			ST_KID: begin
				kval_q <= rdata;
			end
			ST_KID2: begin
				if (rdata > kval_q) begin
					kval_q <= rdata;
					kid_q  <= kid_q + KW'(1);
				end
			end
			ST_CMP: begin
				if (kval_q > carried_q) begin
					hole_q <= kid_q[AW-1:0];
					kid_q  <= kid_next;
				end
			end
			ST_PUT: begin
				if (build_q) begin
					if (top_q == '0) begin
						k_q <= last_q;
					end else begin
						top_q <= top_q - AW'(1);
					end
				end else begin
					k_q <= k_q - AW'(1);
				end
			end
			ST_XR: begin
				kval_q <= rdata;
			end
			ST_XK: begin
				carried_q <= rdata;
				hole_q    <= '0;
				kid_q     <= KW'(1);
				last_q    <= k_q - AW'(1);
			end
			ST_EOUT: begin
				if (out_load) begin
					out_value_q <= rdata;
					out_end_q   <= emit_final;
					out_ovf_q   <= ovf_q;
					emit_idx_q  <= emit_idx_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/hs_checker.sv @@
// Port-level assertions for the heap sorter, bound to the top level.
`timescale 1ns / 1ps
module hs_checker import hs_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     in_is_last,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [ITEM_W-1:0] out_sorted_value,
	input logic                     out_run_end,
	input logic                     out_overflowed
);

	// A closing beat hands the set to the sorter, so loading stops at once.
	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_is_last |=> !in_ready)
	else $error("input still ready after the closing beat of a set");

	// While a run is still being delivered, no new set may start loading.
	a_no_load_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_run_end |-> !in_ready)
	else $error("input ready while a run is only partly delivered");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sorted_value)
			&& $stable(out_run_end) && $stable(out_overflowed))
	else $error("stalled result beat changed");

endmodule

bind heap_sorter_unit hs_checker u_hs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (items.valid),
	.in_ready         (items.ready),
	.in_is_last       (items.is_last),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.out_sorted_value (results.sorted_value),
	.out_run_end      (results.run_end),
	.out_overflowed   (results.overflowed)
);

@@ sim/tb.sv @@
// Self-checking testbench for heap_sorter_unit: sets of signed values in, ascending runs out.
`timescale 1ns / 1ps
module tb;
	import hs_pkg::*;

	localparam int CAPACITY     = DEF_MAX_ITEMS;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_BEATS  = 78;
	localparam int NUM_PHASES   = 4;
	localparam int NUM_DIRECTED = 22;

	localparam logic signed [ITEM_W-1:0] VAL_MAX = {1'b0, {(ITEM_W-1){1'b1}}};
	localparam logic signed [ITEM_W-1:0] VAL_MIN = {1'b1, {(ITEM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [ITEM_W-1:0] sorted_value;
		logic                     run_end;
		logic                     overflowed;
	} sorted_beat_t;

	// One directed beat; exp_value is used only on rows marked typed, which are one-value sets.
	typedef struct packed {
		logic signed [ITEM_W-1:0] value;
		logic                     is_final;
		logic                     typed;
		logic signed [ITEM_W-1:0] exp_value;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{32'sd5,        1'b1, 1'b1, 32'sd5},
		'{VAL_MAX,       1'b1, 1'b1, VAL_MAX},
		'{VAL_MIN,       1'b1, 1'b1, VAL_MIN},
		'{32'sd0,        1'b1, 1'b1, 32'sd0},
		'{-32'sd1,       1'b1, 1'b1, -32'sd1},
		'{VAL_MAX,       1'b0, 1'b0, 32'sd0},
		'{VAL_MIN,       1'b1, 1'b0, 32'sd0},
		'{32'sd7,        1'b0, 1'b0, 32'sd0},
		'{32'sd7,        1'b0, 1'b0, 32'sd0},
		'{-32'sd7,       1'b1, 1'b0, 32'sd0},
		'{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
		'{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
		'{32'sd0,        1'b0, 1'b0, 32'sd0},
		'{32'sd1,        1'b0, 1'b0, 32'sd0},
		'{-32'sd2,       1'b1, 1'b0, 32'sd0},
		'{32'sd4,        1'b0, 1'b0, 32'sd0},
		'{32'sd3,        1'b0, 1'b0, 32'sd0},
		'{32'sd2,        1'b0, 1'b0, 32'sd0},
		'{32'sd1,        1'b0, 1'b0, 32'sd0},
		'{32'sd0,        1'b1, 1'b0, 32'sd0},
		'{-32'sd3,       1'b0, 1'b0, 32'sd0},
		'{-32'sd3,       1'b1, 1'b0, 32'sd0}
	};

	localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 83, 0, 25};
	localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 83, 25};

	logic clk;
	logic arst_n;

	hs_in_if  items_if ();
	hs_out_if results_if ();

	heap_sorter_unit #(
		.MAX_ITEMS(CAPACITY)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	// Shadow of the block's set under construction.
	logic signed [ITEM_W-1:0] shadow_store [CAPACITY];
	int                       shadow_count = 0;
	bit                       shadow_overflow = 0;

	sorted_beat_t expected_sorted_q [$];

	int cycle_count     = 0;
	int error_count     = 0;
	int beats_sent      = 0;
	int sets_closed     = 0;
	int results_checked = 0;
	int overflow_runs   = 0;
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	always @(negedge clk) results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	function automatic void push_sorted(input logic signed [ITEM_W-1:0] value,
			input logic run_end, input logic overflowed);
		sorted_beat_t beat;
		beat.sorted_value = value;
		beat.run_end      = run_end;
		beat.overflowed   = overflowed;
		expected_sorted_q.push_back(beat);
	endfunction

	// Takes one accepted beat into the shadow set; with predict set, a closing beat yields the ascending run.
	function automatic void absorb_element(input logic signed [ITEM_W-1:0] value,
			input logic is_final, input logic predict);
		logic signed [ITEM_W-1:0] held;
		int                       j;
		if (shadow_count < CAPACITY) begin
			shadow_store[shadow_count] = value;
			shadow_count++;
		end else begin
			shadow_overflow = 1'b1;
		end
		if (is_final) begin
			if (predict) begin
				for (int i = 1; i < shadow_count; i++) begin
					held = shadow_store[i];
					j = i - 1;
					while (j >= 0 && shadow_store[j] > held) begin
						shadow_store[j + 1] = shadow_store[j];
						j--;
					end
					shadow_store[j + 1] = held;
				end
				for (int i = 0; i < shadow_count; i++)
					push_sorted(shadow_store[i], i == shadow_count - 1, shadow_overflow);
			end
			if (shadow_overflow)
				overflow_runs++;
			sets_closed++;
			shadow_count    = 0;
			shadow_overflow = 1'b0;
		end
	endfunction

	function automatic logic signed [ITEM_W-1:0] pick_value();
		logic signed [ITEM_W-1:0] value;
		case ($urandom_range(0, 9))
			5, 6: value = $signed($urandom_range(0, 8)) - 4;
			7: value = VAL_MAX;
			8: value = VAL_MIN;
			9: value = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
			default: value = $urandom;
		endcase
		return value;
	endfunction

	// Called and returns at a falling edge; valid stays high across back-to-back beats.
	task automatic send_element(input logic signed [ITEM_W-1:0] value, input logic is_final,
			input logic typed, input logic signed [ITEM_W-1:0] exp_value);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_if.valid         <= 1'b1;
		items_if.element_value <= value;
		items_if.is_last       <= is_final;
		do
			@(posedge clk);
		while (!items_if.ready);
		absorb_element(value, is_final, !typed);
		if (typed && is_final)
			push_sorted(exp_value, 1'b1, 1'b0);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_set(input int size);
		for (int i = 0; i < size; i++)
			send_element(pick_value(), i == size - 1, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_sorted_q.size() == 0) begin
				$error("unexpected result beat: sorted_value %0d", results_if.sorted_value);
				error_count++;
			end else begin
				want = expected_sorted_q.pop_front();
				results_checked++;
				if (results_if.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						want.sorted_value, results_if.sorted_value);
					error_count++;
				end
				if (results_if.run_end !== want.run_end) begin
					$error("run_end: expected %0b, got %0b", want.run_end, results_if.run_end);
					error_count++;
				end
				if (results_if.overflowed !== want.overflowed) begin
					$error("overflowed: expected %0b, got %0b",
						want.overflowed, results_if.overflowed);
					error_count++;
				end
			end
		end
	end

	initial begin
		int phase_start;
		int size;
		arst_n                 = 1'b0;
		items_if.valid         = 1'b0;
		items_if.element_value = '0;
		items_if.is_last       = 1'b0;
		results_if.ready       = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[i])
			send_element(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].is_final,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp_value);

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct  = SEND_IDLE_PCT[p];
			recv_stall_pct = RECV_STALL_PCT[p];
			phase_start    = beats_sent;
			// Each phase opens with a set at, past or just under capacity, then mostly small sets.
			case (p)
				0: send_set(CAPACITY);
				1: send_set(CAPACITY + 1 + $urandom_range(0, 3));
				2: send_set(CAPACITY - 1);
				default: send_set(CAPACITY + 2);
			endcase
			while (beats_sent - phase_start < PHASE_BEATS) begin
				size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
				send_set(size);
			end
		end
		items_if.valid <= 1'b0;

		wait (expected_sorted_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sorted %0d sets from %0d input beats under four idle/stall mixes.",
			sets_closed, beats_sent);
		$display("Checked %0d result beats; %0d runs had dropped values.",
			results_checked, overflow_runs);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
